>>> src/pawn_correction_history_macros.svh
// assertion macros shared by the pawn correction history rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef PAWN_CORRECTION_HISTORY_MACROS_SVH
`define PAWN_CORRECTION_HISTORY_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PCH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pch assertion failed");
// next-cycle implication, checked out of reset
`define PCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pch assertion failed");
`else
`define PCH_ASSERT_IMPL(lbl, ante, cons)
`define PCH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> src/pch_pkg.sv
// shared types and constants of the pawn correction history block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pch_pkg;

  // table geometry default
  localparam int unsigned TABLE_ENTRIES_DEF = 16384;
  localparam int unsigned QUEUE_DEPTH       = 2;

  // field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned DEPTH_W  = 8;
  localparam int unsigned DIFF_W   = 16;
  localparam int unsigned ENTRY_W  = 16;
  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned SCALE_W  = 10;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned UNITS_W  = 6;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPDATE_SCALE     = 2'd0,
    CFG_CORRECTION_LIMIT = 2'd1,
    CFG_EVAL_UNITS       = 2'd2
  } cfg_idx_e;

  localparam logic [SCALE_W-1:0] SCALE_RST = 10'd64;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 11'd64;
  localparam logic [UNITS_W-1:0] UNITS_RST = 6'd1;

  typedef struct packed {
    logic [SCALE_W-1:0] update_scale;
    logic [LIMIT_W-1:0] correction_limit;
    logic [UNITS_W-1:0] eval_units;
  } cfg_t;

  // request kinds
  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  // key reduction: one hex digit of the hash per cycle
  localparam int unsigned KEY_DIGIT_W = 4;

  // queued request: kind, depth, difference, then the slot address
  localparam int unsigned ITEM_FIX_W = 1 + DEPTH_W + DIFF_W;

  // update arithmetic
  localparam int unsigned DD_W         = DIFF_W + DEPTH_W + 1;
  localparam int unsigned PROD_W       = DD_W + SCALE_W + 1;
  localparam int unsigned CHANGE_SHIFT = 6;
  localparam int unsigned FULL_W       = LIMIT_W + UNITS_W;
  localparam int unsigned CHG_W        = FULL_W;
  localparam int unsigned MAG_W        = 16;

  // divides |entry*change| by limit*units, or |entry| by units
  localparam int unsigned DVD_W          = 30;
  localparam int unsigned DVS_W          = FULL_W;
  localparam int unsigned DIV_RADIX_BITS = 2;
  localparam int unsigned DIV_CYCLES     = DVD_W / DIV_RADIX_BITS;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // front sequencer
  typedef enum logic [1:0] {
    F_IDLE,
    F_REDUCE,
    F_PUSH
  } front_state_e;

  // back sequencer
  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_PROD,
    B_CLAMP,
    B_MAG,
    B_DIV,
    B_FIN
  } back_state_e;

endpackage

`default_nettype wire

>>> src/pch_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pch_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/pch_queue.sv
// short request queue between the front and back sequencers
// depends on pawn_correction_history_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pawn_correction_history_macros.svh"

module pch_queue #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             full_o,
  input  wire logic             pop_i,
  output      logic [WIDTH-1:0] data_o,
  output      logic             empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // the front only pushes when there is room
  `PCH_ASSERT_IMPL(queue_no_overflow, push_i, !full_o)

endmodule

`default_nettype wire

>>> src/pch_front.sv
// front sequencer: accepts requests and reduces the hash key to a slot
// depends on pch_pkg and pawn_correction_history_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pawn_correction_history_macros.svh"

module pch_front #(
  parameter int unsigned TABLE_ENTRIES = pch_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned ADDR_W = $clog2(2 * TABLE_ENTRIES),
  localparam int unsigned ITEM_W = pch_pkg::ITEM_FIX_W + ADDR_W
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_stall_o,
  input  wire logic                                 kind_i,
  input  wire logic                                 side_to_move_i,
  input  wire logic [pch_pkg::KEY_W-1:0]            hash_key_i,
  input  wire logic [pch_pkg::DEPTH_W-1:0]          search_depth_i,
  input  wire logic signed [pch_pkg::DIFF_W-1:0]    eval_difference_i,
  input  wire logic                                 clear_busy_i,
  input  wire logic                                 q_full_i,
  output      logic                                 q_push_o,
  output      logic [ITEM_W-1:0]                    q_data_o
);

  import pch_pkg::*;

  localparam int unsigned IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned ACC_W  = IDX_W + KEY_DIGIT_W;
  localparam int unsigned DIGITS = KEY_W / KEY_DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(DIGITS);
  localparam logic [ACC_W-1:0]  MODULUS   = ACC_W'(TABLE_ENTRIES);
  localparam logic [IDX_W:0]    RES_LIMIT = (IDX_W + 1)'(TABLE_ENTRIES);
  localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(TABLE_ENTRIES);
  localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(DIGITS - 1);

  front_state_e             state_q, state_d;
  logic [CNT_W-1:0]         cnt_q;
  logic                     kind_q;
  logic                     side_q;
  logic [DEPTH_W-1:0]       depth_q;
  logic [DIFF_W-1:0]        diff_q;
  logic [KEY_W-1:0]         key_q;
  logic [IDX_W-1:0]         res_q;
  logic [ACC_W-1:0]         acc;
  logic [IDX_W-1:0]         res_step;
  logic [ADDR_W-1:0]        slot;
  logic                     accept;

  // sequencer
  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    q_push_o   = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_stall_o = clear_busy_i;
        if (in_valid_i && !clear_busy_i) begin
          state_d = F_REDUCE;
        end
      end
      F_REDUCE: begin
        if (cnt_q == LAST_CNT) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (state_q == F_REDUCE) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // key modulo table size, one digit per cycle with restoring subtracts
  always_comb begin
    acc = {res_q, key_q[KEY_W-1 -: KEY_DIGIT_W]};
    for (int k = KEY_DIGIT_W - 1; k >= 0; k--) begin
      if (acc >= (MODULUS << k)) begin
        acc = acc - (MODULUS << k);
      end
    end
    res_step = acc[IDX_W-1:0];
  end

  // request payload and reduction state
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      side_q  <= side_to_move_i;
      depth_q <= search_depth_i;
      diff_q  <= eval_difference_i;
      key_q   <= hash_key_i;
      res_q   <= '0;
    end else if (state_q == F_REDUCE) begin
      key_q <= key_q << KEY_DIGIT_W;
      res_q <= res_step;
    end
  end

  // slot in the table half of the side to move
  assign slot     = ADDR_W'(res_q) + (side_q ? HALF_BASE : '0);
  assign q_data_o = {kind_q, depth_q, diff_q, slot};

  `PCH_ASSERT_IMPL(front_residue_range, state_q == F_REDUCE, {1'b0, res_q} < RES_LIMIT)

endmodule

`default_nettype wire

>>> src/pch_div.sv
// iterative unsigned divider, two quotient bits per cycle
// depends on pch_pkg and pawn_correction_history_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pawn_correction_history_macros.svh"

module pch_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pch_pkg::div_req_t req_i,
  output      pch_pkg::div_rsp_t rsp_o
);

  import pch_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_CYCLES);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DIV_CYCLES - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVS_W:0]   rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   r;
  logic [DVD_W-1:0] q;

  // restoring steps of one cycle
  always_comb begin
    r = rem_q;
    q = quo_q;
    for (int s = 0; s < DIV_RADIX_BITS; s++) begin
      r = {r[DVS_W-1:0], q[DVD_W-1]};
      q = {q[DVD_W-2:0], 1'b0};
      if (r >= {1'b0, dvs_q}) begin
        r    = r - {1'b0, dvs_q};
        q[0] = 1'b1;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST_CNT) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= r;
      quo_q <= q;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `PCH_ASSERT_IMPL(div_no_restart, req_i.start, !busy_q)

endmodule

`default_nettype wire

>>> src/pch_back.sv
// back sequencer: table access, gravity update arithmetic and result register
// depends on pch_pkg, pch_ram, pch_div and pawn_correction_history_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "pawn_correction_history_macros.svh"

module pch_back #(
  parameter int unsigned TABLE_ENTRIES = pch_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned ADDR_W = $clog2(2 * TABLE_ENTRIES),
  localparam int unsigned ITEM_W = pch_pkg::ITEM_FIX_W + ADDR_W
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pch_pkg::cfg_t                      cfg_i,
  input  wire logic                               q_empty_i,
  input  wire logic [ITEM_W-1:0]                  q_data_i,
  output      logic                               q_pop_o,
  output      logic                               clear_busy_o,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic signed [pch_pkg::SCORE_W-1:0] correction_score_o
);

  import pch_pkg::*;

  localparam int unsigned DEPTH = 2 * TABLE_ENTRIES;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic signed [PROD_W-1:0] ROUND_BIAS =
    PROD_W'((1 << CHANGE_SHIFT) - 1);

  back_state_e               state_q, state_d;
  logic [ADDR_W-1:0]         clr_addr_q;
  logic                      kind_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [DEPTH_W-1:0]        depth_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic signed [ENTRY_W-1:0] entry_q;
  logic signed [DD_W-1:0]    dd_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [FULL_W-1:0]         full_q;
  logic [UNITS_W-1:0]        units_q;
  logic signed [CHG_W-1:0]   change_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      out_valid_q;
  logic [SCORE_W-1:0]        score_q;

  logic [ADDR_W-1:0]         head_addr;
  logic [LIMIT_W-1:0]        limit_nz;
  logic [UNITS_W-1:0]        units_nz;
  logic [ENTRY_W-1:0]        rdata;
  logic                      we;
  logic [ADDR_W-1:0]         waddr;
  logic [ENTRY_W-1:0]        wdata;
  logic [ENTRY_W:0]          ent_ext;
  logic [ENTRY_W:0]          ent_neg;
  logic [ENTRY_W-1:0]        ent_abs;
  logic [2*MAG_W-1:0]        mag_prod;
  logic signed [PROD_W-1:0]  biased;
  logic signed [PROD_W-1:0]  scaled;
  logic signed [PROD_W-1:0]  bnd;
  logic signed [PROD_W-1:0]  clamped;
  logic [MAG_W-1:0]          mag_d;
  logic [ENTRY_W-1:0]        quo16;
  logic [ENTRY_W-1:0]        signed_quo;
  logic [ENTRY_W-1:0]        new_entry;
  logic                      out_free;
  logic                      out_load;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  assign head_addr = q_data_i[ADDR_W-1:0];
  assign limit_nz  = (cfg_i.correction_limit == '0) ? LIMIT_W'(1) : cfg_i.correction_limit;
  assign units_nz  = (cfg_i.eval_units == '0) ? UNITS_W'(1) : cfg_i.eval_units;
  assign out_free  = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      B_CLEAR: begin
        if (clr_addr_q == LAST_ADDR) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          state_d = B_READ;
        end
      end
      B_READ:  state_d = B_PROD;
      B_PROD:  state_d = B_CLAMP;
      B_CLAMP: state_d = (kind_q == KIND_QUERY) ? B_DIV : B_MAG;
      B_MAG:   state_d = B_DIV;
      B_DIV: begin
        if (div_rsp.done) begin
          state_d = B_FIN;
        end
      end
      B_FIN: begin
        if (kind_q == KIND_UPDATE) begin
          state_d = B_IDLE;
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // table memory, swept to zero after reset
  assign we    = (state_q == B_CLEAR) || (state_q == B_FIN && kind_q == KIND_UPDATE);
  assign waddr = (state_q == B_CLEAR) ? clr_addr_q : addr_q;
  assign wdata = (state_q == B_CLEAR) ? '0 : new_entry;

  pch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (q_pop_o),
    .raddr_i (head_addr),
    .rdata_o (rdata)
  );

  // magnitude of the stored entry
  assign ent_ext = {entry_q[ENTRY_W-1], entry_q};
  assign ent_neg = (ENTRY_W + 1)'(0) - ent_ext;
  assign ent_abs = entry_q[ENTRY_W-1] ? ent_neg[ENTRY_W-1:0] : ent_ext[ENTRY_W-1:0];

  // scaled difference divided by 64 toward zero, then clamped to a quarter of full
  always_comb begin
    biased  = prod_q + (prod_q[PROD_W-1] ? ROUND_BIAS : '0);
    scaled  = biased >>> CHANGE_SHIFT;
    bnd     = $signed({{(PROD_W - FULL_W + 2){1'b0}}, full_q[FULL_W-1:2]});
    clamped = scaled;
    if (scaled > bnd) begin
      clamped = bnd;
    end else if (scaled < -bnd) begin
      clamped = -bnd;
    end
    mag_d = clamped[PROD_W-1] ? MAG_W'(-clamped) : MAG_W'(clamped);
  end

  assign mag_prod = ent_abs * mag_q;

  // divider requests: entry over units for a query, entry*|change| over full for an update
  always_comb begin
    div_req.start    = (state_q == B_CLAMP && kind_q == KIND_QUERY) || (state_q == B_MAG);
    div_req.dividend = (kind_q == KIND_QUERY) ? DVD_W'(ent_abs) : mag_prod[DVD_W-1:0];
    div_req.divisor  = (kind_q == KIND_QUERY) ? DVS_W'(units_q) : full_q;
  end

  pch_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // quotient carries the sign of the entry; the sum wraps to 16 bits
  assign quo16      = div_rsp.quotient[ENTRY_W-1:0];
  assign signed_quo = entry_q[ENTRY_W-1] ? (ENTRY_W'(0) - quo16) : quo16;
  assign new_entry  = entry_q + change_q[ENTRY_W-1:0] - signed_quo;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      kind_q  <= q_data_i[ITEM_W-1];
      depth_q <= q_data_i[ADDR_W + DIFF_W +: DEPTH_W];
      diff_q  <= q_data_i[ADDR_W +: DIFF_W];
      addr_q  <= head_addr;
    end
    if (state_q == B_READ) begin
      entry_q <= rdata;
      dd_q    <= diff_q * $signed({1'b0, depth_q});
      full_q  <= FULL_W'(limit_nz) * FULL_W'(units_nz);
      units_q <= units_nz;
    end
    if (state_q == B_PROD) begin
      prod_q <= dd_q * $signed({1'b0, cfg_i.update_scale});
    end
    if (state_q == B_CLAMP) begin
      change_q <= clamped[CHG_W-1:0];
      mag_q    <= mag_d;
    end
    if (out_load) begin
      score_q <= signed_quo;
    end
  end

  assign clear_busy_o       = (state_q == B_CLEAR);
  assign out_valid_o        = out_valid_q;
  assign correction_score_o = score_q;

  // the gravity term never exceeds the entry magnitude
  `PCH_ASSERT_IMPL(back_quot_bound, state_q == B_FIN && kind_q == KIND_UPDATE,
                   div_rsp.quotient <= DVD_W'(ent_abs))
  // no result leaves while the table is being swept
  `PCH_ASSERT_IMPL(back_no_out_in_clear, state_q == B_CLEAR, !out_valid_q)

endmodule

`default_nettype wire

>>> src/pawn_correction_history.sv
// pawn correction history: the back sequencer takes one request at a time and divides
// with a two-bit-per-cycle divider; an update adds a magnitude step before the divide.
// key reduction in the front overlaps the back sequencer, so the front can take a new
// request before the back is through with the last one. after reset the 2*TABLE_ENTRIES
// table entries (32768 at default) are swept to zero; requests stall during the sweep,
// and configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module pawn_correction_history #(
  parameter int unsigned TABLE_ENTRIES = pch_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pch_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [pch_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic                               kind_i,
  input  wire logic                               side_to_move_i,
  input  wire logic [pch_pkg::KEY_W-1:0]          hash_key_i,
  input  wire logic [pch_pkg::DEPTH_W-1:0]        search_depth_i,
  input  wire logic signed [pch_pkg::DIFF_W-1:0]  eval_difference_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic signed [pch_pkg::SCORE_W-1:0] correction_score_o
);

  import pch_pkg::*;

  localparam int unsigned ADDR_W = $clog2(2 * TABLE_ENTRIES);
  localparam int unsigned ITEM_W = ITEM_FIX_W + ADDR_W;

  cfg_t              cfg_q;
  logic              clear_busy;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_in;
  logic [ITEM_W-1:0] q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.update_scale     <= SCALE_RST;
      cfg_q.correction_limit <= LIMIT_RST;
      cfg_q.eval_units       <= UNITS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_UPDATE_SCALE:     cfg_q.update_scale     <= cfg_data_i[SCALE_W-1:0];
        CFG_CORRECTION_LIMIT: cfg_q.correction_limit <= cfg_data_i[LIMIT_W-1:0];
        CFG_EVAL_UNITS:       cfg_q.eval_units       <= cfg_data_i[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  pch_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .side_to_move_i    (side_to_move_i),
    .hash_key_i        (hash_key_i),
    .search_depth_i    (search_depth_i),
    .eval_difference_i (eval_difference_i),
    .clear_busy_i      (clear_busy),
    .q_full_i          (q_full),
    .q_push_o          (q_push),
    .q_data_o          (q_in)
  );

  pch_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  pch_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .q_empty_i          (q_empty),
    .q_data_i           (q_out),
    .q_pop_o            (q_pop),
    .clear_busy_o       (clear_busy),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .correction_score_o (correction_score_o)
  );

endmodule

`default_nettype wire

>>> dv/pawn_correction_history_tb.sv
// self-checking testbench for pawn_correction_history: directed and random requests
// against an in-bench table predictor; depends on pch_pkg and the pawn_correction_history rtl
`timescale 1ns / 1ps

module pawn_correction_history_tb;
  import pch_pkg::*;

  localparam int unsigned ENTRIES = TABLE_ENTRIES_DEF;
  localparam int unsigned SLOT_W = $clog2(ENTRIES);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;
  localparam longint CHANGE_DIV = 64;
  localparam longint BOUND_DIV = 4;
  localparam int DRAIN_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 170;
  localparam int HOT_SLOTS = 6;

  // stimulus side of the block
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      kind_i = 1'b0;
  logic                      side_to_move_i = 1'b0;
  logic [KEY_W-1:0]          hash_key_i = '0;
  logic [DEPTH_W-1:0]        search_depth_i = '0;
  logic signed [DIFF_W-1:0]  eval_difference_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SCORE_W-1:0] correction_score_o;

  // predictor state: table copy and register copies
  shortint            corr_tbl [2*ENTRIES];
  logic [SCALE_W-1:0] cur_scale = SCALE_RST;
  logic [LIMIT_W-1:0] cur_limit = LIMIT_RST;
  logic [UNITS_W-1:0] cur_units = UNITS_RST;
  shortint            pending_scores [$];

  // idling controls, in percent
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int n_updates = 0;
  int n_queries = 0;
  int n_scores = 0;
  int n_settings = 0;
  int n_mismatches = 0;

  logic [SLOT_W-1:0] hot_slots [HOT_SLOTS] = '{'0, 1, 777, 8192, 12345, ENTRIES - 1};

  // register settings of the random phases; all-ones data checks masking
  logic [CFG_DATA_W-1:0] scale_set [RANDOM_PHASES] = '{64, '1, 300, 0, 1, 97};
  logic [CFG_DATA_W-1:0] limit_set [RANDOM_PHASES] = '{64, '1, 1024, 0, 1, 300};
  logic [CFG_DATA_W-1:0] units_set [RANDOM_PHASES] = '{1, '1, 32, 0, 5, 3};
  int send_pct_set [RANDOM_PHASES] = '{27, 27, 45, 45, 0, 0};
  int recv_pct_set [RANDOM_PHASES] = '{45, 45, 27, 27, 0, 0};

  pawn_correction_history #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .kind_i            (kind_i),
    .side_to_move_i    (side_to_move_i),
    .hash_key_i        (hash_key_i),
    .search_depth_i    (search_depth_i),
    .eval_difference_i (eval_difference_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .correction_score_o(correction_score_o)
  );

  always #2 clk_i = ~clk_i;

  // table address: side picks the half, key modulo the half size picks the entry
  function automatic int unsigned table_slot(logic side, logic [KEY_W-1:0] key);
    return (side ? ENTRIES : 0) + int'(key % KEY_W'(ENTRIES));
  endfunction

  // stored entry scaled down to score units, truncated toward zero
  function automatic shortint score_of(int unsigned slot);
    longint units;
    units = (cur_units == '0) ? 1 : longint'(cur_units);
    return shortint'(longint'(corr_tbl[slot]) / units);
  endfunction

  // gravity update of one entry, exact in 64 bits, stored value wraps to 16
  function automatic void fold_update(int unsigned slot, logic [DEPTH_W-1:0] depth,
                                      logic signed [DIFF_W-1:0] diff);
    longint units, limit, full, bound, change, entry, mag;
    units = (cur_units == '0) ? 1 : longint'(cur_units);
    limit = (cur_limit == '0) ? 1 : longint'(cur_limit);
    full = limit * units;
    bound = full / BOUND_DIV;
    change = longint'(diff) * longint'(depth) * longint'(cur_scale) / CHANGE_DIV;
    if (change > bound) change = bound;
    if (change < -bound) change = -bound;
    mag = (change < 0) ? -change : change;
    entry = longint'(corr_tbl[slot]);
    corr_tbl[slot] = shortint'(entry + change - entry * mag / full);
  endfunction

  // receiver stall
  always @(posedge clk_i)
    out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

  // score checker
  always @(posedge clk_i) begin
    shortint want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_scores.size() == 0) begin
        n_mismatches++;
        if (n_mismatches <= REPORT_LIMIT)
          $display("%0t: score %0d arrived with no query outstanding", $time,
                   correction_score_o);
      end else begin
        want = pending_scores.pop_front();
        n_scores++;
        if (correction_score_o !== want) begin
          n_mismatches++;
          if (n_mismatches <= REPORT_LIMIT)
            $display("%0t: correction_score expected %0d got %0d", $time, want,
                     correction_score_o);
        end
      end
    end
  end

  // one request, with an optional sender gap; the prediction is made on acceptance
  task automatic send_request(kind_e kind, logic side, logic [KEY_W-1:0] key,
                              logic [DEPTH_W-1:0] depth, logic signed [DIFF_W-1:0] diff);
    int unsigned slot;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i        <= 1'b1;
    kind_i            <= kind;
    side_to_move_i    <= side;
    hash_key_i        <= key;
    search_depth_i    <= depth;
    eval_difference_i <= diff;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    slot = table_slot(side, key);
    if (kind == KIND_QUERY) begin
      pending_scores.push_back(score_of(slot));
      n_queries++;
    end else begin
      fold_update(slot, depth, diff);
      n_updates++;
    end
  endtask

  // stop sending, let all scores arrive, then let queued updates finish
  task automatic wait_for_idle();
    in_valid_i <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_UPDATE_SCALE:     cur_scale = data[SCALE_W-1:0];
      CFG_CORRECTION_LIMIT: cur_limit = data[LIMIT_W-1:0];
      CFG_EVAL_UNITS:       cur_units = data[UNITS_W-1:0];
      default: ;
    endcase
  endtask

  // all three registers, optionally followed by a write to the unused index
  task automatic program_regs(logic [CFG_DATA_W-1:0] scale, logic [CFG_DATA_W-1:0] limit,
                              logic [CFG_DATA_W-1:0] units, bit poke_spare);
    wait_for_idle();
    write_reg(CFG_UPDATE_SCALE, scale);
    write_reg(CFG_CORRECTION_LIMIT, limit);
    write_reg(CFG_EVAL_UNITS, units);
    if (poke_spare) write_reg(CFG_SPARE_IDX, '1);
    cfg_we_i <= 1'b0;
    n_settings++;
  endtask

  task automatic send_random_request();
    kind_e                    kind;
    logic                     side;
    logic [KEY_W-1:0]         key;
    logic [DEPTH_W-1:0]       depth;
    logic signed [DIFF_W-1:0] diff;
    kind = ($urandom_range(99) < 40) ? KIND_QUERY : KIND_UPDATE;
    side = 1'($urandom_range(1));
    key = {$urandom, $urandom};
    // most requests land on a few slots so entries build up over many updates
    if ($urandom_range(99) < 80) key[SLOT_W-1:0] = hot_slots[$urandom_range(HOT_SLOTS - 1)];
    depth = ($urandom_range(99) < 70) ? DEPTH_W'($urandom_range(12)) : DEPTH_W'($urandom);
    diff = ($urandom_range(99) < 70) ? DIFF_W'(int'($urandom_range(600)) - 300)
                                     : DIFF_W'($urandom);
    send_request(kind, side, key, depth, diff);
  endtask

  // reset settings: fresh entries, clamping at both extremes, key aliasing, both halves
  task automatic test_reset_defaults();
    send_request(KIND_QUERY, 1'b0, '0, '0, '0);
    send_request(KIND_QUERY, 1'b1, '1, '0, '0);
    send_request(KIND_UPDATE, 1'b0, '0, 8'd255, 16'sh7FFF);
    send_request(KIND_UPDATE, 1'b1, '1, 8'd255, 16'sh8000);
    send_request(KIND_QUERY, 1'b0, 64'h8000_0000_0000_0000, '0, '0);
    send_request(KIND_QUERY, 1'b1, 64'h0000_0000_0000_3FFF, '0, '0);
    send_request(KIND_UPDATE, 1'b0, '0, 8'd0, 16'sh7FFF);
    send_request(KIND_UPDATE, 1'b0, '0, 8'd1, 16'sh0000);
    send_request(KIND_UPDATE, 1'b1, '1, 8'd1, 16'sd3);
    send_request(KIND_UPDATE, 1'b0, 64'h5555_AAAA_5555_AAAA, 8'd3, -16'sd1);
    send_request(KIND_QUERY, 1'b0, '0, '1, '1);
    send_request(KIND_QUERY, 1'b1, '1, '0, '0);
    send_request(KIND_QUERY, 1'b0, 64'h5555_AAAA_5555_AAAA, '0, '0);
    send_request(KIND_QUERY, 1'b1, 64'h5555_AAAA_5555_AAAA, '0, '0);
  endtask

  // largest registers: full-size changes push entries past 16 bits both ways
  task automatic test_wraparound();
    program_regs('1, '1, '1, 1'b0);
    repeat (3) begin
      send_request(KIND_UPDATE, 1'b0, 64'h0123_4567_89AB_CDEF, 8'd255, 16'sh7FFF);
      send_request(KIND_QUERY, 1'b0, 64'h0123_4567_89AB_CDEF, '0, '0);
    end
    repeat (3) begin
      send_request(KIND_UPDATE, 1'b1, 64'hFEDC_BA98_7654_3210, 8'd255, 16'sh8000);
      send_request(KIND_QUERY, 1'b1, 64'hFEDC_BA98_7654_3210, '0, '0);
    end
  endtask

  // zero limit and zero units act as one; zero scale freezes entries;
  // a write to the unused index changes nothing
  task automatic test_zero_registers();
    program_regs(11'd64, '0, 11'd5, 1'b1);
    send_request(KIND_UPDATE, 1'b0, 64'h40, 8'd10, 16'sd100);
    send_request(KIND_QUERY, 1'b0, 64'h40, '0, '0);
    program_regs(11'd64, 11'd8, '0, 1'b0);
    send_request(KIND_UPDATE, 1'b0, 64'h40, 8'd255, 16'sh8000);
    send_request(KIND_QUERY, 1'b0, 64'h40, '0, '0);
    program_regs('0, 11'd100, 11'd1, 1'b0);
    send_request(KIND_UPDATE, 1'b0, 64'h40, 8'd255, 16'sh7FFF);
    send_request(KIND_QUERY, 1'b0, 64'h40, '0, '0);
  endtask

  // random traffic over several register settings and idling patterns
  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      send_idle_pct = send_pct_set[p];
      recv_idle_pct = recv_pct_set[p];
      program_regs(scale_set[p], limit_set[p], units_set[p], 1'b0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_random_request();
        // hold off once until every outstanding score is back
        if (p == 1 && i == PHASE_ITEMS / 2) begin
          in_valid_i <= 1'b0;
          do begin
            @(posedge clk_i);
          end while (pending_scores.size() != 0);
        end
      end
    end
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 45;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_wraparound();
    test_zero_registers();
    test_random_traffic();
    wait_for_idle();
    $display("ran %0d updates and %0d queries over %0d register settings,",
             n_updates, n_queries, n_settings + 1);
    $display("%0d scores checked, %0d mismatches", n_scores, n_mismatches);
    if (n_mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #3_000_000;
    $display("timeout with %0d scores outstanding", pending_scores.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/pch_pkg.sv
src/pch_ram.sv
src/pch_queue.sv
src/pch_front.sv
src/pch_div.sv
src/pch_back.sv
src/pawn_correction_history.sv
dv/pawn_correction_history_tb.sv
